>>> rtl/stok_pkg.sv
// ----------------------------------------------------------------------------
// stok_pkg: shared definitions for the S-expression tokenizer
// Result kinds, tokenizer modes, register indexes, character codes, the
// result record and the configuration write record.
// ----------------------------------------------------------------------------
package stok_pkg;

  localparam int unsigned MAX_ATOM_LEN = 255;
  localparam int unsigned CNT_W        = 8;
  localparam int unsigned POS_W        = 16;

  typedef enum logic [2:0] {
    KIND_OPEN  = 3'd0,
    KIND_CLOSE = 3'd1,
    KIND_QUOTE = 3'd2,
    KIND_BYTE  = 3'd3,
    KIND_DONE  = 3'd4,
    KIND_EOS   = 3'd5,
    KIND_ERR   = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_ATOM = 2'd1,
    MODE_HALT = 2'd2
  } mode_e;

  typedef enum logic {
    REG_FIRST_LINE   = 1'b0,
    REG_FIRST_COLUMN = 1'b1
  } reg_idx_e;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_QUOTE  = 8'h27;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         data_byte;
    logic [POS_W-1:0]   token_line;
    logic [POS_W-1:0]   token_column;
    logic [7:0]         atom_length;
    logic               last;
  } stok_res_t;

  typedef struct packed {
    logic             we;
    reg_idx_e         idx;
    logic [POS_W-1:0] wdata;
  } stok_cfg_t;

  // Saturating increment of a position counter.
  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
    sat_inc = (&v) ? v : v + POS_W'(1);
  endfunction

endpackage

>>> rtl/stok_core.sv
// ----------------------------------------------------------------------------
// stok_core: tokenizer state and per-byte classification
// Holds mode, atom length and position counters; turns one accepted item
// into zero, one or two result records in a single combinational pass.
// ----------------------------------------------------------------------------
module stok_core
  import stok_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_en_i,
  input  logic [7:0]       in_byte_i,
  input  logic             in_eoi_i,
  input  stok_cfg_t        cfg_i,
  output stok_res_t [1:0]  res_o,
  output logic [1:0]       res_cnt_o
);

  mode_e            mode_q, mode_d, mode_s;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_s;
  logic [POS_W-1:0] line_q, line_d, line_s;
  logic [POS_W-1:0] col_q, col_d, col_s;
  logic [POS_W-1:0] sline_q, sline_d, sline_s;
  logic [POS_W-1:0] scol_q, scol_d, scol_s;

  stok_res_t [1:0]  res;
  logic [1:0]       n;
  logic             slot;
  logic             idle_go;
  logic             do_byte;
  logic [CNT_W:0]   cnt1;

  always_comb begin
    mode_s  = mode_q;
    cnt_s   = cnt_q;
    line_s  = line_q;
    col_s   = col_q;
    sline_s = sline_q;
    scol_s  = scol_q;
    res     = '0;
    n       = 2'd0;
    slot    = 1'b0;
    idle_go = 1'b0;
    do_byte = 1'b0;
    cnt1    = '0;

    unique case (mode_q)
      MODE_IDLE, MODE_ATOM: begin
        if (in_eoi_i) begin
          if (mode_q == MODE_ATOM) begin
            res[0].kind         = KIND_DONE;
            res[0].token_line   = sline_q;
            res[0].token_column = scol_q;
            res[0].atom_length  = cnt_q;
            slot                = 1'b1;
          end
          res[slot].kind         = KIND_EOS;
          res[slot].token_line   = line_q;
          res[slot].token_column = col_q;
          n      = {1'b0, slot} + 2'd1;
          cnt_s  = '0;
          mode_s = MODE_HALT;
        end else if (mode_q == MODE_ATOM) begin
          case (in_byte_i) inside
            CH_SPACE, CH_TAB, CH_OPEN, CH_CLOSE, CH_CR, CH_LF: begin
              res[0].kind         = KIND_DONE;
              res[0].token_line   = sline_q;
              res[0].token_column = scol_q;
              res[0].atom_length  = cnt_q;
              n       = 2'd1;
              slot    = 1'b1;
              cnt_s   = '0;
              mode_s  = MODE_IDLE;
              idle_go = 1'b1;
            end
            default: begin
              do_byte = 1'b1;
            end
          endcase
        end else begin
          idle_go = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Handling of a byte between tokens; the slot follows any atom-done.
    if (idle_go) begin
      case (in_byte_i) inside
        CH_SPACE, CH_TAB: begin
          col_s = sat_inc(col_q);
        end
        CH_LF: begin
          line_s = sat_inc(line_q);
          col_s  = POS_W'(1);
        end
        CH_OPEN, CH_CLOSE, CH_QUOTE: begin
          res[slot].kind = (in_byte_i == CH_OPEN)  ? KIND_OPEN  :
                           (in_byte_i == CH_CLOSE) ? KIND_CLOSE : KIND_QUOTE;
          res[slot].token_line   = line_q;
          res[slot].token_column = col_q;
          n     = {1'b0, slot} + 2'd1;
          col_s = sat_inc(col_q);
        end
        CH_CR: begin
          res[slot].kind         = KIND_ERR;
          res[slot].token_line   = line_q;
          res[slot].token_column = col_q;
          n      = {1'b0, slot} + 2'd1;
          mode_s = MODE_HALT;
        end
        default: begin
          // A new atom starts here; only reached from between tokens.
          mode_s  = MODE_ATOM;
          sline_s = line_q;
          scol_s  = col_q;
          do_byte = 1'b1;
        end
      endcase
    end

    if (do_byte) begin
      cnt1 = (mode_q == MODE_ATOM) ? {1'b0, cnt_q} + (CNT_W+1)'(1) : (CNT_W+1)'(1);
      res[0].kind         = KIND_BYTE;
      res[0].data_byte    = in_byte_i;
      res[0].token_line   = sline_s;
      res[0].token_column = scol_s;
      col_s               = sat_inc(col_q);
      n                   = 2'd1;
      if (cnt1 >= (CNT_W+1)'(MAX_ATOM_LEN)) begin
        res[1].kind         = KIND_DONE;
        res[1].token_line   = sline_s;
        res[1].token_column = scol_s;
        res[1].atom_length  = cnt1[CNT_W] ? 8'hFF : cnt1[7:0];
        n      = 2'd2;
        cnt_s  = '0;
        mode_s = MODE_IDLE;
      end else begin
        cnt_s = cnt1[CNT_W-1:0];
      end
    end

    if (n == 2'd2) begin
      res[1].last = 1'b1;
    end else if (n == 2'd1) begin
      res[0].last = 1'b1;
    end
  end

  // Commit on a consumed item; a register write reloads its counter at once.
  always_comb begin
    mode_d  = step_en_i ? mode_s  : mode_q;
    cnt_d   = step_en_i ? cnt_s   : cnt_q;
    line_d  = step_en_i ? line_s  : line_q;
    col_d   = step_en_i ? col_s   : col_q;
    sline_d = step_en_i ? sline_s : sline_q;
    scol_d  = step_en_i ? scol_s  : scol_q;
    if (cfg_i.we) begin
      unique case (cfg_i.idx)
        REG_FIRST_LINE:   line_d = cfg_i.wdata;
        REG_FIRST_COLUMN: col_d  = cfg_i.wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      cnt_q   <= '0;
      line_q  <= POS_W'(1);
      col_q   <= POS_W'(1);
      sline_q <= '0;
      scol_q  <= '0;
    end else begin
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      line_q  <= line_d;
      col_q   <= col_d;
      sline_q <= sline_d;
      scol_q  <= scol_d;
    end
  end

  assign res_o     = res;
  assign res_cnt_o = n;

  // Once halted, only a reset brings the tokenizer back.
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_HALT |=> mode_q == MODE_HALT)
    else $error("tokenizer left the halted mode");

  // When an item gives two results, one of them closes an atom: either the
  // first (a delimiter or end of input after an atom) or the second (the
  // byte that brings an atom to its length limit).
  a_pair_has_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && res_cnt_o == 2'd2 |->
      (res_o[0].kind == KIND_DONE || res_o[1].kind == KIND_DONE))
    else $error("two results without an atom-done");

endmodule

>>> rtl/stok_obuf.sv
// ----------------------------------------------------------------------------
// stok_obuf: two-entry result buffer
// Takes the zero, one or two results of an item at once and hands them
// out one per transaction on the output stream.
// ----------------------------------------------------------------------------
module stok_obuf
  import stok_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  stok_res_t [1:0] res_i,
  input  logic [1:0]      res_cnt_i,
  output logic            can_take_o,
  output logic            valid_o,
  input  logic            ready_i,
  output stok_res_t       head_o
);

  stok_res_t [1:0] slot_q, slot_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            pop;

  assign pop        = (cnt_q != 2'd0) && ready_i;
  assign can_take_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && ready_i);

  always_comb begin
    slot_d = slot_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      slot_d = res_i;
      cnt_d  = res_cnt_i;
    end else if (pop) begin
      slot_d[0] = slot_q[1];
      cnt_d     = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = slot_q[0];

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result buffer holds more than two entries");

  // A full buffer holds the two results of one item, so its head is not last.
  a_full_head_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !slot_q[0].last)
    else $error("head of a full result buffer is marked last");

endmodule

>>> rtl/sexpr_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// sexpr_tokenizer_unit: byte-serial S-expression tokenizer
// Input register, tokenizer core and two-entry result buffer behind a
// stream interface, plus a plain register write port.
// ----------------------------------------------------------------------------
// One text byte (or an end-of-input mark) enters per transaction and the
// block takes a new one every cycle while the output side is ready and each
// byte gives at most one result; a byte with two results (an atom-done
// followed by a paren, a CR or an end-of-stream, or a full-length atom's
// last byte and its done) holds the input side until the result buffer has
// room, since the output stream moves at most one result per cycle. The
// rate is set by that output port. Items are held in the input register,
// results in the buffer. Parens and quote give a token tagged with its start
// line and column; other bytes form atoms, each byte passed on and closed by
// an atom-done that carries the length (at most 255 bytes, then the atom is
// closed). A CR between tokens gives an error result and end of input gives
// an end-of-stream result; either halts the block, which then swallows all
// further input without results until reset. Writing register 0 or 1 sets
// the current line or column at once; write only while the block is idle.
// ----------------------------------------------------------------------------
module sexpr_tokenizer_unit
  import stok_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream. tdata: in_byte[7:0]. tuser: end_of_input[0].
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,
  input  logic [0:0]  s_tuser_i,
  // Output stream. tdata: data_byte[7:0], token_line[23:8],
  // token_column[39:24], atom_length[47:40]. tuser: kind[2:0].
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [47:0] m_tdata_o,
  output logic [2:0]  m_tuser_o,
  output logic        m_tlast_o,
  // Register write port: 0 first_line, 1 first_column.
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  // Input register: holds one item until the result buffer has room for
  // everything it may produce.
  logic       in_v_q, in_v_d;
  logic [7:0] in_byte_q, in_byte_d;
  logic       in_eoi_q, in_eoi_d;
  logic       can_take;
  logic       step_en;
  logic       load;

  stok_cfg_t       cfg;
  stok_res_t [1:0] res;
  logic [1:0]      res_cnt;
  stok_res_t       head;

  assign step_en    = in_v_q && can_take;
  assign s_tready_o = !in_v_q || step_en;
  assign load       = s_tvalid_i && s_tready_o;

  always_comb begin
    in_v_d    = load ? 1'b1 : (step_en ? 1'b0 : in_v_q);
    in_byte_d = load ? s_tdata_i    : in_byte_q;
    in_eoi_d  = load ? s_tuser_i[0] : in_eoi_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= in_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
    in_eoi_q  <= in_eoi_d;
  end

  assign cfg.we    = cfg_we_i;
  assign cfg.idx   = reg_idx_e'(cfg_idx_i[0]);
  assign cfg.wdata = cfg_wdata_i;

  stok_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .in_byte_i (in_byte_q),
    .in_eoi_i  (in_eoi_q),
    .cfg_i     (cfg),
    .res_o     (res),
    .res_cnt_o (res_cnt)
  );

  stok_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (step_en),
    .res_i      (res),
    .res_cnt_i  (res_cnt),
    .can_take_o (can_take),
    .valid_o    (m_tvalid_o),
    .ready_i    (m_tready_i),
    .head_o     (head)
  );

  assign m_tdata_o = {head.atom_length, head.token_column, head.token_line,
                      head.data_byte};
  assign m_tuser_o = head.kind;
  assign m_tlast_o = head.last;

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sexpr_tokenizer_unit
// Streams S-expression text into the tokenizer with bursty input and a
// stalling output side, predicts every token in a cycle-free model and
// compares each output transaction field by field in order of arrival.
// ----------------------------------------------------------------------------
module testbench;
  import stok_pkg::*;

  // One pending text transaction: a byte or the end-of-input mark.
  typedef struct packed {
    logic       eoi;
    logic [7:0] b;
  } text_item_t;

  // A short fixed text that touches every token kind that does not halt the
  // block, both byte extremes and each non-halting byte that closes an atom.
  localparam logic [7:0] INTRO [20] = '{
    CH_OPEN, CH_CLOSE, CH_QUOTE, CH_SPACE, CH_TAB, CH_LF,
    8'h00, 8'hFF, CH_OPEN,         // atom closed by an open paren
    8'h41, CH_SPACE,               // atom closed by a space
    8'h7E, CH_TAB,                 // atom closed by a tab
    8'h01, CH_LF,                  // atom closed by a newline
    8'h80, CH_QUOTE, 8'h62,        // a quote inside an atom is just a byte
    CH_CLOSE, CH_LF                // atom closed by a close paren
  };

  localparam int unsigned LONG_HOLD = 300;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        s_tvalid_i  = 1'b0;
  logic        s_tready_o;
  logic [7:0]  s_tdata_i   = '0;
  logic [0:0]  s_tuser_i   = '0;
  logic        m_tvalid_o;
  logic        m_tready_i  = 1'b0;
  logic [47:0] m_tdata_o;
  logic [2:0]  m_tuser_o;
  logic        m_tlast_o;
  logic        cfg_we_i    = 1'b0;
  logic [0:0]  cfg_idx_i   = '0;
  logic [15:0] cfg_wdata_i = '0;

  // Pending text, tokens still owed by the block, and the tokens of the
  // transaction being predicted right now.
  text_item_t text_q  [$];
  stok_res_t  token_q [$];
  stok_res_t  step_q  [$];

  // Lexer state of the prediction and its copy of the two registers.
  mode_e       lex_mode     = MODE_IDLE;
  int unsigned atom_len     = 0;
  logic [15:0] first_line_r = 16'd1;
  logic [15:0] first_col_r  = 16'd1;
  logic [15:0] line_cnt     = 16'd1;
  logic [15:0] col_cnt      = 16'd1;
  logic [15:0] atom_line    = 16'd0;
  logic [15:0] atom_col     = 16'd0;

  int unsigned err_cnt    = 0;
  int unsigned pushed_cnt = 0;

  // Sender burst state.
  text_item_t  cur;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  // Receiver stall state.
  int unsigned cyc_cnt   = 0;
  int unsigned hold_left = 0;
  int unsigned seg_left  = 0;
  int unsigned seg_mode  = 0;
  bit          hold_done = 1'b0;

  stok_res_t   want;

  sexpr_tokenizer_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o),
    .m_tlast_o   (m_tlast_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Token prediction
  // --------------------------------------------------------------------------

  // Line and column counters stick at their top value.
  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // Bytes that close an open atom.
  function automatic bit is_break(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_OPEN || b == CH_CLOSE ||
           b == CH_CR || b == CH_LF;
  endfunction

  task automatic push_token(input kind_e k, input logic [7:0] d,
                            input logic [15:0] ln, input logic [15:0] col,
                            input logic [7:0] len);
    stok_res_t r;
    r.kind         = k;
    r.data_byte    = d;
    r.token_line   = ln;
    r.token_column = col;
    r.atom_length  = len;
    r.last         = 1'b0;
    step_q.push_back(r);
  endtask

  task automatic close_atom();
    push_token(KIND_DONE, 8'h00, atom_line, atom_col,
               (atom_len > 255) ? 8'hFF : atom_len[7:0]);
    atom_len = 0;
    lex_mode = MODE_IDLE;
  endtask

  // One byte of an atom; the byte that fills the atom up to its length
  // limit also closes it, so the next byte starts a fresh atom.
  task automatic atom_step(input logic [7:0] b);
    push_token(KIND_BYTE, b, atom_line, atom_col, 8'h00);
    col_cnt  = bump(col_cnt);
    atom_len = atom_len + 1;
    if (atom_len >= MAX_ATOM_LEN) close_atom();
  endtask

  task automatic between_tokens(input logic [7:0] b);
    case (b)
      CH_SPACE, CH_TAB: begin
        col_cnt = bump(col_cnt);
      end
      CH_LF: begin
        line_cnt = bump(line_cnt);
        col_cnt  = 16'd1;
      end
      CH_OPEN: begin
        push_token(KIND_OPEN, 8'h00, line_cnt, col_cnt, 8'h00);
        col_cnt = bump(col_cnt);
      end
      CH_CLOSE: begin
        push_token(KIND_CLOSE, 8'h00, line_cnt, col_cnt, 8'h00);
        col_cnt = bump(col_cnt);
      end
      CH_QUOTE: begin
        push_token(KIND_QUOTE, 8'h00, line_cnt, col_cnt, 8'h00);
        col_cnt = bump(col_cnt);
      end
      CH_CR: begin
        // A carriage return outside an atom is an error and halts the lexer.
        push_token(KIND_ERR, 8'h00, line_cnt, col_cnt, 8'h00);
        lex_mode = MODE_HALT;
      end
      default: begin
        lex_mode  = MODE_ATOM;
        atom_len  = 0;
        atom_line = line_cnt;
        atom_col  = col_cnt;
        atom_step(b);
      end
    endcase
  endtask

  // Works out the tokens of one accepted transaction and queues them, the
  // final one of the transaction flagged as last.
  task automatic tokenize(input logic [7:0] b, input logic eoi);
    stok_res_t r;
    step_q.delete();
    if (lex_mode != MODE_HALT) begin
      if (eoi) begin
        if (lex_mode == MODE_ATOM) close_atom();
        push_token(KIND_EOS, 8'h00, line_cnt, col_cnt, 8'h00);
        lex_mode = MODE_HALT;
      end else if (lex_mode == MODE_ATOM) begin
        if (is_break(b)) begin
          close_atom();
          between_tokens(b);
        end else begin
          atom_step(b);
        end
      end else begin
        between_tokens(b);
      end
    end
    if (step_q.size() != 0) begin
      r = step_q.pop_back();
      r.last = 1'b1;
      step_q.push_back(r);
    end
    foreach (step_q[i]) token_q.push_back(step_q[i]);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic push_text(input logic eoi, input logic [7:0] b);
    text_item_t it;
    it.eoi = eoi;
    it.b   = b;
    text_q.push_back(it);
    pushed_cnt = pushed_cnt + 1;
  endtask

  // An atom of the given length made of random non-delimiter bytes.
  task automatic push_atom(input int unsigned len);
    logic [7:0] b;
    repeat (len) begin
      do b = 8'($urandom_range(0, 255)); while (is_break(b));
      push_text(1'b0, b);
    end
  endtask

  // Mostly well-formed text: parens, quotes, whitespace and short atoms,
  // now and then an atom near or past the length limit, plus some stray bytes.
  // A carriage return would halt the block, so it never appears here.
  task automatic gen_text(input int unsigned n_items);
    int unsigned start;
    int unsigned pick;
    logic [7:0]  b;
    start = pushed_cnt;
    while (pushed_cnt - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_CR) b = CH_SPACE;
        push_text(1'b0, b);
      end else if (pick < 26) begin
        case ($urandom_range(0, 2))
          0:       push_text(1'b0, CH_OPEN);
          1:       push_text(1'b0, CH_CLOSE);
          default: push_text(1'b0, CH_QUOTE);
        endcase
      end else if (pick < 48) begin
        case ($urandom_range(0, 5))
          0, 1, 2: push_text(1'b0, CH_SPACE);
          3:       push_text(1'b0, CH_TAB);
          default: push_text(1'b0, CH_LF);
        endcase
      end else begin
        push_atom(($urandom_range(0, 199) == 0) ? $urandom_range(240, 300)
                                                : $urandom_range(1, 8));
      end
    end
  endtask

  // Register writes happen only with the block idle, so the prediction can
  // take the new counter value at once.
  task automatic write_reg(input reg_idx_e idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    if (idx == REG_FIRST_LINE) begin
      first_line_r = value;
      line_cnt     = value;
    end else begin
      first_col_r = value;
      col_cnt     = value;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until all text is in and all tokens are out, then lets the
  // pipeline drain bytes that cause no token.
  task automatic wait_idle();
    while (text_q.size() != 0 || s_tvalid_i || token_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic report(input string msg);
    err_cnt = err_cnt + 1;
    if (err_cnt <= 40) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned exp_v);
    if (got != exp_v)
      report($sformatf("%s is %0d, should be %0d", name, got, exp_v));
  endtask

  // --------------------------------------------------------------------------
  // Input driver: bursts of random length separated by random gaps. Every
  // accepted transaction is handed to the prediction right away.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid_i <= 1'b0;
    end else begin
      if (s_tvalid_i && s_tready_o) tokenize(s_tdata_i, s_tuser_i[0]);
      if (!s_tvalid_i || s_tready_o) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          s_tvalid_i <= 1'b0;
        end else if (text_q.size() != 0) begin
          cur = text_q.pop_front();
          s_tvalid_i <= 1'b1;
          s_tdata_i  <= cur.b;
          s_tuser_i  <= cur.eoi;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left = burst_left - 1;
          end
        end else begin
          s_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output ready: segments of always-ready, coin-flip and one-in-four
  // patterns. Once, while the sender is offering text, the ready line is
  // held low for a long stretch so the result buffer and the input register
  // fill up and the input side has to stall.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready_i <= 1'b0;
    end else begin
      cyc_cnt = cyc_cnt + 1;
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        m_tready_i <= 1'b0;
      end else if (!hold_done && cyc_cnt > 800 && s_tvalid_i) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        m_tready_i <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_mode = $urandom_range(0, 2);
          seg_left = $urandom_range(8, 80);
        end else begin
          seg_left = seg_left - 1;
        end
        case (seg_mode)
          0:       m_tready_i <= 1'b1;
          1:       m_tready_i <= 1'($urandom_range(0, 1));
          default: m_tready_i <= (seg_left % 4 == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: each output transaction is checked against the oldest
  // predicted token. tdata holds data_byte, token_line, token_column and
  // atom_length from the lowest bit up; tuser holds the kind.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (token_q.size() == 0) begin
        report($sformatf("token of kind %0d arrived with none predicted", m_tuser_o));
      end else begin
        want = token_q.pop_front();
        check_field("kind",         m_tuser_o,         want.kind);
        check_field("data_byte",    m_tdata_o[7:0],    want.data_byte);
        check_field("token_line",   m_tdata_o[23:8],   want.token_line);
        check_field("token_column", m_tdata_o[39:24],  want.token_column);
        check_field("atom_length",  m_tdata_o[47:40],  want.atom_length);
        check_field("last",         m_tlast_o,         want.last);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned wait_cyc;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fixed text at the reset position.
    foreach (INTRO[i]) push_text(1'b0, INTRO[i]);
    wait_idle();

    // Counters at zero, and one atom well past the length limit.
    write_reg(REG_FIRST_LINE, 16'h0000);
    write_reg(REG_FIRST_COLUMN, 16'h0000);
    push_atom(300);
    gen_text(320);
    wait_idle();

    // Line counter at its top and column one below, so they saturate early.
    write_reg(REG_FIRST_LINE, 16'hFFFF);
    write_reg(REG_FIRST_COLUMN, 16'hFFFE);
    gen_text(320);
    wait_idle();

    write_reg(REG_FIRST_COLUMN, 16'($urandom_range(0, 65535)));
    write_reg(REG_FIRST_LINE, 16'($urandom_range(0, 65535)));
    gen_text(320);
    wait_idle();

    write_reg(REG_FIRST_LINE, 16'h0001);
    write_reg(REG_FIRST_COLUMN, 16'h0001);
    gen_text(320);

    // Reset comes only once, so the halting cases close the run: end of
    // input or a carriage return, either between tokens or inside an atom.
    case ($urandom_range(0, 3))
      0: begin
        push_text(1'b0, CH_SPACE);
        push_text(1'b1, 8'($urandom_range(0, 255)));
      end
      1: begin
        push_atom($urandom_range(1, 4));
        push_text(1'b1, 8'($urandom_range(0, 255)));
      end
      2: begin
        push_text(1'b0, CH_SPACE);
        push_text(1'b0, CH_CR);
      end
      default: begin
        push_atom($urandom_range(1, 4));
        push_text(1'b0, CH_CR);
      end
    endcase
    // Once halted the block must swallow everything silently.
    repeat (8) push_text(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));

    while (text_q.size() != 0 || s_tvalid_i) @(posedge clk_i);
    for (wait_cyc = 0; wait_cyc < 20000 && token_q.size() != 0; wait_cyc++)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (token_q.size() != 0)
      report($sformatf("%0d predicted tokens never arrived", token_q.size()));

    if (err_cnt == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

>>> filelist.f
rtl/stok_pkg.sv
rtl/stok_core.sv
rtl/stok_obuf.sv
rtl/sexpr_tokenizer_unit.sv
dv/testbench.sv
